@@ rtl/ptsd_pkg.sv @@
// Shared constants and types for the point to segment distance unit.
`timescale 1ns / 1ps
package ptsd_pkg;

    localparam int DIST_W = 17;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_END   = 2'd1,
        MODE_LINE  = 2'd2
    } t_mode;

endpackage

@@ rtl/ptsd_front.sv @@
// Front pipeline: differences, products, case selection and the squared numerator.
`timescale 1ns / 1ps
module ptsd_front #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [W-1:0]         i_px,
    input  logic [W-1:0]         i_py,
    input  logic [W-1:0]         i_ax,
    input  logic [W-1:0]         i_ay,
    input  logic [W-1:0]         i_bx,
    input  logic [W-1:0]         i_by,
    output logic                 o_vld,
    output logic [4*W+1:0]       o_num,
    output logic [2*W:0]         o_den
);
    localparam int H  = W + 1;
    localparam int NW = 4 * W + 2;
    localparam int DW = 2 * W + 1;

    logic [5:0] r_vld;

    // stage 1
    logic signed [W:0] r1_dx, r1_dy, r1_wx, r1_wy, r1_vx, r1_vy;
    // stage 2
    logic signed [2*W+1:0] r2_dxx, r2_dyy, r2_dxw, r2_dyw, r2_cxa, r2_cxb;
    logic signed [2*W+1:0] r2_wxx, r2_wyy, r2_vxx, r2_vyy;
    // stage 3
    logic signed [2*W+2:0] r3_dd, r3_dot, r3_crs, r3_pa, r3_pb;
    // stage 4
    ptsd_pkg::t_mode r4_mode, n4_mode;
    logic [DW-1:0] r4_cabs, r4_dd, r4_pa, r4_pb;
    logic signed [2*W+3:0] w4_diff;
    // stage 5
    ptsd_pkg::t_mode r5_mode;
    logic [2*W-1:0]  r5_phh;
    logic [2*W:0]    r5_phl;
    logic [2*W+1:0]  r5_pll;
    logic [DW-1:0]   r5_dd, r5_pa, r5_pb;
    // stage 6
    logic [NW-1:0] r6_num, n6_num;
    logic [DW-1:0] r6_den, n6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_comb begin
        w4_diff = {r3_dot[2*W+2], r3_dot} - {r3_dd[2*W+2], r3_dd};
        if (r3_dot[2*W+2] || (r3_dot == '0)) begin
            n4_mode = ptsd_pkg::MODE_START;
        end else if (!w4_diff[2*W+3]) begin
            n4_mode = ptsd_pkg::MODE_END;
        end else begin
            n4_mode = ptsd_pkg::MODE_LINE;
        end
    end

    always_comb begin
        unique case (r5_mode)
            ptsd_pkg::MODE_LINE: begin
                n6_num = ({{(NW-2*W){1'b0}}, r5_phh} << (2 * H))
                       + ({{(NW-2*W-1){1'b0}}, r5_phl} << (H + 1))
                       + {{(NW-2*W-2){1'b0}}, r5_pll};
                n6_den = r5_dd;
            end
            ptsd_pkg::MODE_START: begin
                n6_num = {{(NW-DW){1'b0}}, r5_pa};
                n6_den = DW'(1);
            end
            ptsd_pkg::MODE_END: begin
                n6_num = {{(NW-DW){1'b0}}, r5_pb};
                n6_den = DW'(1);
            end
            default: begin
                n6_num = '0;
                n6_den = DW'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx <= $signed({i_bx[W-1], i_bx}) - $signed({i_ax[W-1], i_ax});
            r1_dy <= $signed({i_by[W-1], i_by}) - $signed({i_ay[W-1], i_ay});
            r1_wx <= $signed({i_px[W-1], i_px}) - $signed({i_ax[W-1], i_ax});
            r1_wy <= $signed({i_py[W-1], i_py}) - $signed({i_ay[W-1], i_ay});
            r1_vx <= $signed({i_px[W-1], i_px}) - $signed({i_bx[W-1], i_bx});
            r1_vy <= $signed({i_py[W-1], i_py}) - $signed({i_by[W-1], i_by});

            r2_dxx <= r1_dx * r1_dx;
            r2_dyy <= r1_dy * r1_dy;
            r2_dxw <= r1_dx * r1_wx;
            r2_dyw <= r1_dy * r1_wy;
            r2_cxa <= r1_dx * r1_wy;
            r2_cxb <= r1_dy * r1_wx;
            r2_wxx <= r1_wx * r1_wx;
            r2_wyy <= r1_wy * r1_wy;
            r2_vxx <= r1_vx * r1_vx;
            r2_vyy <= r1_vy * r1_vy;

            r3_dd  <= {r2_dxx[2*W+1], r2_dxx} + {r2_dyy[2*W+1], r2_dyy};
            r3_dot <= {r2_dxw[2*W+1], r2_dxw} + {r2_dyw[2*W+1], r2_dyw};
            r3_crs <= {r2_cxa[2*W+1], r2_cxa} - {r2_cxb[2*W+1], r2_cxb};
            r3_pa  <= {r2_wxx[2*W+1], r2_wxx} + {r2_wyy[2*W+1], r2_wyy};
            r3_pb  <= {r2_vxx[2*W+1], r2_vxx} + {r2_vyy[2*W+1], r2_vyy};

            r4_mode <= n4_mode;
            r4_cabs <= r3_crs[2*W+2] ? DW'(-r3_crs) : r3_crs[DW-1:0];
            r4_dd   <= r3_dd[DW-1:0];
            r4_pa   <= r3_pa[DW-1:0];
            r4_pb   <= r3_pb[DW-1:0];

            // split |cross| so each partial product stays narrow
            r5_mode <= r4_mode;
            r5_phh  <= r4_cabs[DW-1:H] * r4_cabs[DW-1:H];
            r5_phl  <= {1'b0, r4_cabs[DW-1:H]} * r4_cabs[H-1:0];
            r5_pll  <= r4_cabs[H-1:0] * r4_cabs[H-1:0];
            r5_dd   <= r4_dd;
            r5_pa   <= r4_pa;
            r5_pb   <= r4_pb;

            r6_num <= n6_num;
            r6_den <= n6_den;
        end
    end

    assign o_vld = r_vld[5];
    assign o_num = r6_num;
    assign o_den = r6_den;

endmodule

@@ rtl/ptsd_root_step.sv @@
// One bit of the square root of num / den, one register stage.
`timescale 1ns / 1ps
module ptsd_root_step #(
    parameter int W   = 16,
    parameter int BIT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [4*W+1:0]   i_rem,
    input  logic [3*W+2:0]   i_acc,
    input  logic [2*W:0]     i_den,
    input  logic [W+1:0]     i_root,
    output logic             o_vld,
    output logic [4*W+1:0]   o_rem,
    output logic [3*W+2:0]   o_acc,
    output logic [2*W:0]     o_den,
    output logic [W+1:0]     o_root
);
    localparam int NW = 4 * W + 2;
    localparam int UW = 3 * W + 3;
    localparam int DW = 2 * W + 1;
    localparam int RW = W + 2;
    localparam int TW = 4 * W + 7;

    logic          r_vld;
    logic [NW-1:0] r_rem, n_rem;
    logic [UW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_den;
    logic [RW-1:0] r_root, n_root;
    logic [TW-1:0] w_trial, w_rem_ext, w_left;
    logic          w_take;

    // (r + 2^b)^2 * den - r^2 * den = (r*den) << (b+1) + den << 2b
    always_comb begin
        w_trial   = ({{(TW-UW){1'b0}}, i_acc} << (BIT + 1))
                  + ({{(TW-DW){1'b0}}, i_den} << (2 * BIT));
        w_rem_ext = {{(TW-NW){1'b0}}, i_rem};
        w_left    = w_rem_ext - w_trial;
        w_take    = (w_trial <= w_rem_ext);
        n_rem     = w_take ? w_left[NW-1:0] : i_rem;
        n_acc     = w_take ? (i_acc + ({{(UW-DW){1'b0}}, i_den} << BIT)) : i_acc;
        n_root    = i_root | (RW'(w_take) << BIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_den  <= i_den;
            r_root <= n_root;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;
    assign o_den  = r_den;
    assign o_root = r_root;

endmodule

@@ rtl/point_to_segment_distance_unit.sv @@
// Top level of the point to segment distance unit.
// Usage:
//   Slave stream carries one query per beat: P, segment start A and end B as
//   signed COORD_WIDTH-bit coordinates. Master stream returns one beat per
//   query with floor of the Euclidean distance from P to segment AB.
//   Results come back in input order, one per query.
// Pipeline: 6 front stages plus COORD_WIDTH + 2 root stages, 24 registers at
//   COORD_WIDTH = 16.
// Throughput: one query per cycle unless stalled; the root is found one bit
//   per stage in a chain of COORD_WIDTH + 2 registered add and compare steps.
// Stall: the whole pipe advances only while the output register is empty or
//   being taken; o_s_axis_tready follows that enable, so a held result
//   keeps its value and nothing is dropped or repeated.
// Reset: i_rst_n low clears every valid bit; the pipe comes out empty and
//   ready.
`timescale 1ns / 1ps
module point_to_segment_distance_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // query_x, query_y, start_x, start_y, end_x, end_y, zero pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // distance_out, zero pad
    output logic [((ptsd_pkg::DIST_W+7)/8)*8-1:0]  o_m_axis_tdata
);
    localparam int W    = COORD_WIDTH;
    localparam int RW   = W + 2;
    localparam int NW   = 4 * W + 2;
    localparam int UW   = 3 * W + 3;
    localparam int DW   = 2 * W + 1;
    localparam int DSTW = ptsd_pkg::DIST_W;
    localparam int OW   = ((DSTW + 7) / 8) * 8;

    logic          w_en;
    logic          w_front_vld;
    logic [NW-1:0] w_front_num;
    logic [DW-1:0] w_front_den;

    logic          w_vld  [RW+1];
    logic [NW-1:0] w_rem  [RW+1];
    logic [UW-1:0] w_acc  [RW+1];
    logic [DW-1:0] w_den  [RW+1];
    logic [RW-1:0] w_root [RW+1];

    logic [RW+DSTW-1:0] w_root_ext;

    // advance when the output slot is free or drains this cycle
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    ptsd_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_axis_tvalid),
        .i_px    (i_s_axis_tdata[W-1:0]),
        .i_py    (i_s_axis_tdata[2*W-1:W]),
        .i_ax    (i_s_axis_tdata[3*W-1:2*W]),
        .i_ay    (i_s_axis_tdata[4*W-1:3*W]),
        .i_bx    (i_s_axis_tdata[5*W-1:4*W]),
        .i_by    (i_s_axis_tdata[6*W-1:5*W]),
        .o_vld   (w_front_vld),
        .o_num   (w_front_num),
        .o_den   (w_front_den)
    );

    assign w_vld[0]  = w_front_vld;
    assign w_rem[0]  = w_front_num;
    assign w_acc[0]  = '0;
    assign w_den[0]  = w_front_den;
    assign w_root[0] = '0;

    for (genvar g = 0; g < RW; g++) begin : g_root
        ptsd_root_step #(.W(W), .BIT(RW - 1 - g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_rem   (w_rem[g]),
            .i_acc   (w_acc[g]),
            .i_den   (w_den[g]),
            .i_root  (w_root[g]),
            .o_vld   (w_vld[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_den   (w_den[g+1]),
            .o_root  (w_root[g+1])
        );
    end

    assign w_root_ext      = {{DSTW{1'b0}}, w_root[RW]};
    assign o_m_axis_tvalid = w_vld[RW];
    assign o_m_axis_tdata  = {{(OW-DSTW){1'b0}}, w_root_ext[DSTW-1:0]};

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_front_vld) && $stable(w_vld[1]) && $stable(o_m_axis_tdata))
        else $error("pipe moved during stall");

    a_front_to_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_front_vld |=> w_vld[1])
        else $error("front result lost entering root chain");

endmodule
